FILE: rtl/morton_order_sort_macros.svh
// ----------------------------------------------------------------------------
// morton_order_sort_macros
// Assertion macros shared by the Morton sorter RTL.
// ----------------------------------------------------------------------------
`ifndef MORTON_ORDER_SORT_MACROS_SVH
`define MORTON_ORDER_SORT_MACROS_SVH
// Clocked implication with reset disable
`define MOS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication with reset disable
`define MOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Shared constants, types and helper functions of the Morton sorter.
// ----------------------------------------------------------------------------
package mos_pkg;
    localparam int MaxParticles = 1024;
    localparam int DigitBits    = 8;
    localparam int AxisBits     = 21;
    localparam int IdxW         = $clog2(MaxParticles);
    localparam int CntW         = IdxW + 1;
    localparam int NumDigits    = 1 << DigitBits;
    localparam int KeyBits      = 3 * AxisBits;
    localparam int NumPasses    = (KeyBits + DigitBits - 1) / DigitBits;
    localparam int PassW        = (NumPasses > 1) ? $clog2(NumPasses) : 1;
    localparam int NumW         = 34;
    localparam int DivW         = NumW + AxisBits - 1;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StEmpty = 2'd2;

    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdFetch = 1'b1;

    // Classified request handed from front to back
    typedef struct packed {
        logic              fetch;
        logic              last;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } req_t;

    function automatic logic [62:0] interleave(input logic [AxisBits-1:0] x,
                                               input logic [AxisBits-1:0] y,
                                               input logic [AxisBits-1:0] z);
        logic [62:0] k;
        k = '0;
        for (int b = 0; b < AxisBits; b++) begin
            k[3*b]   = x[b];
            k[3*b+1] = y[b];
            k[3*b+2] = z[b];
        end
        return k;
    endfunction
endpackage

FILE: rtl/morton_order_sort.sv
// ----------------------------------------------------------------------------
// morton_order_sort
// Morton (Z-order) key generator and stable LSD radix sorter.
// ----------------------------------------------------------------------------
// A load quantises each axis with a bit-serial divider, one division per
// axis, then a store state registers the result and writes the key. A load
// flagged last then starts the sort: an index fill, then 8 passes of digit
// clear, count, prefix sum, scatter and copy, and one closing state. The
// back part takes no request while the sort runs or a result waits. A fetch
// reads the order table, then the key store, and then registers the result.
// The input queue holds two requests, so the front keeps accepting until it
// is full while the back part works or the result waits.
module morton_order_sort (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic                s_last_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [9:0]          m_original_index,
    output logic [62:0]         m_zorder_key,
    output logic                m_final_entry,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam logic [1:0] RegCx = 2'd0;
    localparam logic [1:0] RegCy = 2'd1;
    localparam logic [1:0] RegCz = 2'd2;
    localparam logic [1:0] RegHs = 2'd3;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        hs_reg;
    logic               q_valid, q_ready;
    mos_pkg::req_t      q_req;

    assign pready = 1'b1;

    // Register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            hs_reg <= 31'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                RegCx: cx_reg <= pwdata;
                RegCy: cy_reg <= pwdata;
                RegCz: cz_reg <= pwdata;
                RegHs: hs_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegCx:   prdata = cx_reg;
            RegCy:   prdata = cy_reg;
            RegCz:   prdata = cz_reg;
            default: prdata = {1'b0, hs_reg};
        endcase
    end

    mos_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_pos_x, .s_pos_y, .s_pos_z,
        .s_last_item, .q_valid, .q_ready, .q_req
    );

    mos_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .center_x(cx_reg), .center_y(cy_reg), .center_z(cz_reg), .cell_half(hs_reg),
        .m_valid, .m_ready, .m_status, .m_original_index, .m_zorder_key, .m_final_entry
    );
endmodule

FILE: rtl/mos_front.sv
// ----------------------------------------------------------------------------
// mos_front
// Input stage: takes requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mos_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic                 s_last_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output mos_pkg::req_t        q_req
);
    mos_pkg::req_t slot_reg [2];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_req   = slot_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wp_reg] <= '{fetch: (s_cmd == mos_pkg::CmdFetch), last: s_last_item,
                                  px: s_pos_x, py: s_pos_y, pz: s_pos_z};
        end
    end

    `include "morton_order_sort_macros.svh"
    `MOS_ASSERT_IMPL(a_no_push_full, aclk, aresetn, cnt_reg == 2'd2, !push, "push into full queue")
    `MOS_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, cnt_reg == 2'd0, !pop, "pop from empty queue")
    `MOS_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3, "queue count overflow")
endmodule

FILE: rtl/mos_divider.sv
// ----------------------------------------------------------------------------
// mos_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mos_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mos_pkg::DivW-1:0]    dividend,
    input  logic [30:0]                 divisor,
    output logic                        done,
    output logic [mos_pkg::DivW-1:0]    quotient
);
    localparam int StepW = $clog2(mos_pkg::DivW + 1);
    logic [mos_pkg::DivW-1:0] q_reg;
    logic [31:0]              r_reg;
    logic [30:0]              d_reg;
    logic [StepW-1:0]         step_reg;
    logic                     busy_reg, done_reg;
    logic [32:0]              trial;

    assign trial    = {r_reg, q_reg[mos_pkg::DivW-1]} - {2'b0, d_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == StepW'(mos_pkg::DivW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[mos_pkg::DivW-2:0], 1'b1};
            end else begin
                r_reg <= {r_reg[30:0], q_reg[mos_pkg::DivW-1]};
                q_reg <= {q_reg[mos_pkg::DivW-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/mos_back.sv
// ----------------------------------------------------------------------------
// mos_back
// Executes loads (quantise, interleave, store), the radix sort and fetches.
// ----------------------------------------------------------------------------
module mos_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  mos_pkg::req_t        q_req,
    input  logic signed [31:0]   center_x,
    input  logic signed [31:0]   center_y,
    input  logic signed [31:0]   center_z,
    input  logic [30:0]          cell_half,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [9:0]           m_original_index,
    output logic [62:0]          m_zorder_key,
    output logic                 m_final_entry
);
    localparam int IdxW = mos_pkg::IdxW;
    localparam int CntW = mos_pkg::CntW;
    localparam int DW   = mos_pkg::DigitBits;
    localparam logic [CntW-1:0] CapCnt = CntW'(mos_pkg::MaxParticles);

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_STORE, S_INIT, S_CLR, S_CNT, S_CNT2, S_CNT3, S_PFX, S_PFX2,
        S_SCAT, S_SCAT1, S_SCAT2, S_SCAT3, S_COPY, S_COPY2, S_FETCH, S_FETCH2, S_OUT
    } state_t;

    state_t state_reg;
    logic [62:0]      key_store [mos_pkg::MaxParticles];
    logic [IdxW-1:0]  order_ping [mos_pkg::MaxParticles];
    logic [IdxW-1:0]  order_pong [mos_pkg::MaxParticles];
    logic [CntW-1:0]  digit_counts [mos_pkg::NumDigits];

    logic [CntW-1:0]  loaded_reg, fptr_reg, i_reg, sum_reg;
    logic [DW:0]      d_reg;
    logic [mos_pkg::PassW-1:0] pass_reg;
    logic             sorted_reg, last_reg, nonpos_reg;
    logic [1:0]       axis_reg;
    logic [mos_pkg::AxisBits-1:0] code_reg [3];
    mos_pkg::req_t    req_reg;
    logic [62:0]      key_rd_reg;
    logic [IdxW-1:0]  ping_rd_reg;
    logic [CntW-1:0]  cnt_rd_reg;
    logic             out_valid_reg;
    logic [1:0]       out_st_reg;
    logic [9:0]       out_idx_reg;
    logic [62:0]      out_key_reg;
    logic             out_fin_reg;

    logic             div_start, div_done;
    logic [mos_pkg::DivW-1:0] div_q;
    logic [30:0]      h_eff;
    logic signed [33:0] num;
    logic signed [31:0] pos_sel, ctr_sel;
    logic [1:0]       axis_sel;
    mos_pkg::req_t    req_sel;
    logic [DW-1:0]    digit;
    logic [6:0]       shift;

    // The first axis starts straight from the queue, later ones from the held request
    assign axis_sel = (state_reg == S_IDLE) ? 2'd0 : axis_reg + 2'd1;
    assign req_sel  = (state_reg == S_IDLE) ? q_req : req_reg;

    assign h_eff = (cell_half == '0) ? 31'd1 : cell_half;
    always_comb begin
        unique case (axis_sel)
            2'd0:    begin pos_sel = req_sel.px; ctr_sel = center_x; end
            2'd1:    begin pos_sel = req_sel.py; ctr_sel = center_y; end
            default: begin pos_sel = req_sel.pz; ctr_sel = center_z; end
        endcase
    end
    assign num   = 34'(pos_sel) - 34'(ctr_sel) + $signed({3'b0, h_eff});
    assign shift = 7'(pass_reg) * 7'(DW);
    assign digit = DW'(key_rd_reg >> shift);
    assign div_start = (state_reg == S_IDLE && q_valid && !q_req.fetch && !out_valid_reg)
                    || (state_reg == S_DIV && div_done && axis_reg != 2'd2);

    mos_divider u_div (
        .aclk, .aresetn, .start(div_start),
        .dividend(mos_pkg::DivW'({num[32:0], {(mos_pkg::AxisBits-1){1'b0}}})),
        .divisor(h_eff), .done(div_done), .quotient(div_q)
    );

    assign q_ready = (state_reg == S_IDLE) && !out_valid_reg && q_valid;
    assign m_valid          = out_valid_reg;
    assign m_status         = out_st_reg;
    assign m_original_index = out_idx_reg;
    assign m_zorder_key     = out_key_reg;
    assign m_final_entry    = out_fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            fptr_reg      <= '0;
            sorted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            axis_reg      <= 2'd0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (div_start) nonpos_reg <= (num <= 0);
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && !out_valid_reg) begin
                        if (q_req.fetch) begin
                            if (sorted_reg && fptr_reg < loaded_reg) begin
                                ping_rd_reg <= order_ping[fptr_reg[IdxW-1:0]];
                                state_reg   <= S_FETCH;
                            end else begin
                                out_valid_reg <= 1'b1;
                                out_st_reg    <= mos_pkg::StEmpty;
                                out_idx_reg   <= '0;
                                out_key_reg   <= '0;
                                out_fin_reg   <= 1'b0;
                            end
                        end else begin
                            req_reg  <= q_req;
                            last_reg <= q_req.last;
                            if (sorted_reg) begin
                                sorted_reg <= 1'b0;
                                loaded_reg <= '0;
                                fptr_reg   <= '0;
                            end
                            axis_reg  <= 2'd0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        code_reg[axis_reg] <= nonpos_reg ? '0 :
                            ((|div_q[mos_pkg::DivW-1:mos_pkg::AxisBits]) ? '1 :
                             div_q[mos_pkg::AxisBits-1:0]);
                        if (axis_reg == 2'd2) state_reg <= S_STORE;
                        else axis_reg <= axis_reg + 2'd1;
                    end
                end
                S_STORE: begin
                    out_valid_reg <= 1'b1;
                    out_key_reg   <= mos_pkg::interleave(code_reg[0], code_reg[1], code_reg[2]);
                    out_fin_reg   <= 1'b0;
                    if (loaded_reg < CapCnt) begin
                        key_store[loaded_reg[IdxW-1:0]] <=
                            mos_pkg::interleave(code_reg[0], code_reg[1], code_reg[2]);
                        out_st_reg  <= mos_pkg::StOk;
                        out_idx_reg <= 10'(loaded_reg);
                        loaded_reg  <= loaded_reg + 1'b1;
                    end else begin
                        out_st_reg  <= mos_pkg::StFull;
                        out_idx_reg <= '0;
                    end
                    axis_reg <= 2'd0;
                    i_reg    <= '0;
                    pass_reg <= '0;
                    state_reg <= last_reg ? S_INIT : S_IDLE;
                end
                S_INIT: begin
                    if (i_reg == loaded_reg) begin
                        d_reg <= '0;
                        state_reg <= S_CLR;
                    end else begin
                        order_ping[i_reg[IdxW-1:0]] <= i_reg[IdxW-1:0];
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_CLR: begin
                    digit_counts[d_reg[DW-1:0]] <= '0;
                    if (d_reg[DW-1:0] == '1) begin
                        i_reg <= '0;
                        state_reg <= S_CNT;
                    end
                    d_reg <= d_reg + 1'b1;
                end
                // Histogram does not depend on order: walk the keys in load order
                S_CNT: begin
                    if (i_reg == loaded_reg) begin
                        d_reg <= '0;
                        sum_reg <= '0;
                        state_reg <= S_PFX;
                    end else begin
                        key_rd_reg <= key_store[i_reg[IdxW-1:0]];
                        state_reg <= S_CNT2;
                    end
                end
                S_CNT2: begin
                    cnt_rd_reg <= digit_counts[digit];
                    state_reg <= S_CNT3;
                end
                S_CNT3: begin
                    digit_counts[digit] <= cnt_rd_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_CNT;
                end
                S_PFX: begin
                    cnt_rd_reg <= digit_counts[d_reg[DW-1:0]];
                    state_reg <= S_PFX2;
                end
                S_PFX2: begin
                    digit_counts[d_reg[DW-1:0]] <= sum_reg;
                    sum_reg <= sum_reg + cnt_rd_reg;
                    d_reg <= d_reg + 1'b1;
                    if (d_reg[DW-1:0] == '1) begin
                        i_reg <= '0;
                        state_reg <= S_SCAT;
                    end else begin
                        state_reg <= S_PFX;
                    end
                end
                S_SCAT: begin
                    if (i_reg == loaded_reg) begin
                        i_reg <= '0;
                        state_reg <= S_COPY;
                    end else begin
                        ping_rd_reg <= order_ping[i_reg[IdxW-1:0]];
                        state_reg <= S_SCAT1;
                    end
                end
                S_SCAT1: begin
                    key_rd_reg <= key_store[ping_rd_reg];
                    state_reg <= S_SCAT2;
                end
                S_SCAT2: begin
                    cnt_rd_reg <= digit_counts[digit];
                    state_reg <= S_SCAT3;
                end
                S_SCAT3: begin
                    order_pong[cnt_rd_reg[IdxW-1:0]] <= ping_rd_reg;
                    digit_counts[digit] <= cnt_rd_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_SCAT;
                end
                S_COPY: begin
                    if (i_reg == loaded_reg) begin
                        if (pass_reg == mos_pkg::PassW'(mos_pkg::NumPasses - 1)) begin
                            sorted_reg <= 1'b1;
                            fptr_reg   <= '0;
                            state_reg  <= S_OUT;
                        end else begin
                            pass_reg <= pass_reg + 1'b1;
                            d_reg <= '0;
                            state_reg <= S_CLR;
                        end
                    end else begin
                        ping_rd_reg <= order_pong[i_reg[IdxW-1:0]];
                        state_reg <= S_COPY2;
                    end
                end
                S_COPY2: begin
                    order_ping[i_reg[IdxW-1:0]] <= ping_rd_reg;
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_COPY;
                end
                S_FETCH: begin
                    key_rd_reg <= key_store[ping_rd_reg];
                    state_reg <= S_FETCH2;
                end
                S_FETCH2: begin
                    out_valid_reg <= 1'b1;
                    out_st_reg    <= mos_pkg::StOk;
                    out_idx_reg   <= 10'(ping_rd_reg);
                    out_key_reg   <= key_rd_reg;
                    out_fin_reg   <= (fptr_reg + 1'b1 == loaded_reg);
                    fptr_reg      <= fptr_reg + 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `include "morton_order_sort_macros.svh"
    `MOS_ASSERT_IMPL(a_fptr_le, aclk, aresetn, 1'b1, fptr_reg <= loaded_reg, "fetch pointer ahead")
    `MOS_ASSERT_IMPL(a_cnt_cap, aclk, aresetn, 1'b1, loaded_reg <= CapCnt, "count over capacity")
    `MOS_ASSERT_NEXT(a_fetch_out, aclk, aresetn, state_reg == S_FETCH2, out_valid_reg, "fetch lost result")
endmodule

FILE: verif/morton_order_sort_tb.sv
// ----------------------------------------------------------------------------
// morton_order_sort_tb
// Self-checking bench for the Morton sorter: loads random and edge positions,
// sorts sets of assorted sizes, fetches them back and compares every response
// against an in-bench key generator and stable sort model.
// ----------------------------------------------------------------------------
module morton_order_sort_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              cmd;
        logic signed [31:0] px, py, pz;
        logic              last;
    } pos_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  idx;
        logic [62:0] key;
        logic        fin;
    } sort_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic s_cmd = 1'b0, s_last_item = 1'b0;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic m_valid, m_ready = 1'b0;
    logic [1:0] m_status;
    logic [9:0] m_original_index;
    logic [62:0] m_zorder_key;
    logic m_final_entry;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    localparam logic [3:0] AddrCx = 4'd0, AddrCy = 4'd4, AddrCz = 4'd8, AddrHalf = 4'd12;

    morton_order_sort dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Predictor state: own copy of configuration and particle store
    logic signed [31:0] ctr_x = 0, ctr_y = 0, ctr_z = 0;
    logic [30:0] half_edge = 31'd65536;
    logic [62:0] key_mem [mos_pkg::MaxParticles];
    int unsigned sort_order [mos_pkg::MaxParticles];
    int unsigned n_loaded = 0, next_fetch = 0;
    bit set_sorted = 0;

    pos_req_t   pending_reqs[$];
    sort_resp_t expected_resps[$];
    int errors = 0, n_resp = 0, n_fetch_ok = 0, n_sets = 0;
    int unsigned cycle = 0;
    bit no_idle = 0, hold_sender = 0;
    int s_gap = 0, m_gap = 0;

    function automatic logic [mos_pkg::AxisBits-1:0] quantise(logic signed [31:0] p,
                                                             logic signed [31:0] c);
        logic signed [63:0] num;
        logic [63:0] h, q;
        h = (half_edge == 0) ? 64'd1 : {33'd0, half_edge};
        num = 64'(p) - 64'(c) + $signed(h);
        if (num <= 0) return '0;
        q = (64'(num) << (mos_pkg::AxisBits - 1)) / h;
        return (q > 64'((1 << mos_pkg::AxisBits) - 1)) ? {mos_pkg::AxisBits{1'b1}} :
               q[mos_pkg::AxisBits-1:0];
    endfunction

    function automatic logic [62:0] zkey_of(logic signed [31:0] x, y, z);
        logic [mos_pkg::AxisBits-1:0] qx, qy, qz;
        logic [62:0] k;
        qx = quantise(x, ctr_x);
        qy = quantise(y, ctr_y);
        qz = quantise(z, ctr_z);
        k = '0;
        for (int b = 0; b < mos_pkg::AxisBits; b++) begin
            k[3*b] = qx[b];
            k[3*b+1] = qy[b];
            k[3*b+2] = qz[b];
        end
        return k;
    endfunction

    // Stable ordering by key; insertion sort keeps equal keys in load order
    task automatic order_by_key();
        int unsigned v;
        int j;
        for (int i = 0; i < n_loaded; i++) sort_order[i] = i;
        for (int i = 1; i < n_loaded; i++) begin
            v = sort_order[i];
            j = i - 1;
            while (j >= 0 && key_mem[sort_order[j]] > key_mem[v]) begin
                sort_order[j+1] = sort_order[j];
                j--;
            end
            sort_order[j+1] = v;
        end
    endtask

    task automatic predict_response(pos_req_t r);
        sort_resp_t e;
        e = '{mos_pkg::StOk, '0, '0, 1'b0};
        if (r.cmd == mos_pkg::CmdLoad) begin
            if (set_sorted) begin
                set_sorted = 0;
                n_loaded = 0;
                next_fetch = 0;
            end
            e.key = zkey_of(r.px, r.py, r.pz);
            if (n_loaded < mos_pkg::MaxParticles) begin
                key_mem[n_loaded] = e.key;
                e.idx = n_loaded[9:0];
                n_loaded++;
            end else begin
                e.status = mos_pkg::StFull;
            end
            if (r.last) begin
                order_by_key();
                set_sorted = 1;
                next_fetch = 0;
                n_sets++;
            end
        end else if (set_sorted && next_fetch < n_loaded) begin
            e.idx = sort_order[next_fetch][9:0];
            e.key = key_mem[sort_order[next_fetch]];
            next_fetch++;
            e.fin = (next_fetch == n_loaded);
            n_fetch_ok++;
        end else begin
            e.status = mos_pkg::StEmpty;
        end
        expected_resps.push_back(e);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0d] mismatch on %s: got %0h, expected %0h", cycle, what, got, want);
    endtask

    // Driver: present the oldest pending request, idle in random bursts
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_response(pending_reqs.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                    s_gap <= $urandom_range(1, 18);
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_sender) begin
                    pos_req_t r;
                    r = pending_reqs[0];
                    s_valid <= 1'b1;
                    s_cmd <= r.cmd;
                    s_pos_x <= r.px;
                    s_pos_y <= r.py;
                    s_pos_z <= r.pz;
                    s_last_item <= r.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each response with the oldest prediction, stall randomly
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_resp++;
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected response", m_status, 0);
                end else begin
                    sort_resp_t e;
                    e = expected_resps.pop_front();
                    if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                    if (m_original_index !== e.idx)
                        report_mismatch("original_index", m_original_index, e.idx);
                    if (m_zorder_key !== e.key)
                        report_mismatch("zorder_key", m_zorder_key, e.key);
                    if (m_final_entry !== e.fin)
                        report_mismatch("final_entry", m_final_entry, e.fin);
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                m_gap <= $urandom_range(1, 18);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            AddrCx: ctr_x = data;
            AddrCy: ctr_y = data;
            AddrCz: ctr_z = data;
            default: half_edge = data[30:0];
        endcase
    endtask

    // Wait until all requests are through and every response has been seen
    task automatic drain();
        while (pending_reqs.size() != 0 || s_valid || expected_resps.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
            default: return $signed($urandom_range(0, 512)) - 256;
        endcase
    endfunction

    task automatic add_load(logic signed [31:0] x, y, z, logic last);
        pending_reqs.push_back('{mos_pkg::CmdLoad, x, y, z, last});
    endtask

    task automatic add_fetch(logic last);
        pending_reqs.push_back('{mos_pkg::CmdFetch, $urandom, $urandom, $urandom, last});
    endtask

    // One set: loads with random content, then enough fetches to drain it plus extra ones
    task automatic add_set(int n, int mode, int extra);
        for (int i = 0; i < n; i++)
            add_load(rand_pos(mode), rand_pos(mode), rand_pos(mode), i == n - 1);
        for (int i = 0; i < n + extra; i++) add_fetch($urandom_range(0, 1));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: edges, ties, fetch before sort, stray last mark on fetch
        add_fetch(1'b1);
        add_load(32'sh7fffffff, 32'sh80000000, 32'sd0, 1'b0);
        add_load(32'sh80000000, 32'sh7fffffff, 32'sh0000ffff, 1'b0);
        add_load(32'sd0, 32'sd0, 32'sd0, 1'b0);
        add_load(32'sd0, 32'sd0, 32'sd0, 1'b0);
        add_load(-32'sd65536, 32'sd65536, 32'sd65535, 1'b0);
        add_load(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 1'b1);
        for (int i = 0; i < 7; i++) add_fetch(1'b1);
        add_load(32'sd1, 32'sd2, 32'sd3, 1'b1);
        add_fetch(1'b0);
        add_fetch(1'b0);
        drain();

        // Extremes of the configuration, half size zero treated as one
        apb_write(AddrCx, 32'h7fffffff);
        apb_write(AddrCy, 32'h80000000);
        apb_write(AddrCz, 32'h00010000);
        apb_write(AddrHalf, 32'h00000000);
        add_set(6, 2, 1);
        add_set(5, 0, 1);
        drain();
        apb_write(AddrHalf, 32'h7fffffff);
        apb_write(AddrCx, 32'h80000000);
        add_set(8, 0, 1);
        drain();

        // A larger set, then hold the sender until every prediction has been met
        apb_write(AddrCx, 32'h0);
        apb_write(AddrCy, 32'h0);
        apb_write(AddrCz, 32'h0);
        apb_write(AddrHalf, 32'h00020000);
        add_set(40, 1, 2);
        add_set(3, 1, 0);
        while (pending_reqs.size() > 10) @(posedge aclk);
        hold_sender = 1;
        while (s_valid || expected_resps.size() != 0) @(posedge aclk);
        hold_sender = 0;
        drain();

        // Random sets with assorted geometries
        for (int s = 0; s < 25; s++) begin
            if (s % 8 == 7) begin
                drain();
                apb_write(AddrCx, $urandom);
                apb_write(AddrCy, $urandom_range(0, 200000) - 100000);
                apb_write(AddrCz, $urandom);
                apb_write(AddrHalf, $urandom_range(1, 1 << 20));
            end
            if (s == 19) no_idle = 1;
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) add_fetch($urandom_range(0, 1));
                else add_load(rand_pos(0), rand_pos(0), rand_pos(0), 1'b0);
            end
            add_set($urandom_range(1, 14), $urandom_range(0, 2), $urandom_range(0, 2));
        end
        drain();

        $display("Covered %0d sorted sets and %0d responses, %0d of them sorted entries.",
                 n_sets, n_resp, n_fetch_ok);
        if (errors == 0) begin
            $display("morton_order_sort_tb OK");
        end else begin
            $display("morton_order_sort_tb NOT OK");
        end
        $finish;
    end

    // Watchdog: slow loads, small-set sorts and stalls fit well inside
    always @(posedge aclk) begin
        if (cycle > 3000000) begin
            $display("morton_order_sort_tb NOT OK");
            $finish;
        end
    end
endmodule
